FILE: rtl/core/lsm_pkg.sv
// Shared constants, types and byte folding for the line substring matcher.
package lsm_pkg;

	localparam int MAX_KEY_LEN = 16;
	localparam int KEY_BYTES   = 16;
	localparam int KEY_IDX_W   = $clog2(KEY_BYTES);
	localparam int LEN_W       = 5;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 64;

	localparam logic [7:0] BYTE_NEWLINE = 8'd10;
	localparam logic [7:0] BYTE_NUL     = 8'd0;
	localparam logic [7:0] BYTE_LOWER_A = 8'd97;
	localparam logic [7:0] BYTE_LOWER_Z = 8'd122;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	typedef enum logic [1:0] {
		REG_KEY_LOW     = 2'd0,
		REG_KEY_HIGH    = 2'd1,
		REG_KEY_LEN     = 2'd2,
		REG_IGNORE_CASE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0]      key_low;
		logic [63:0]      key_high;
		logic [LEN_W-1:0] key_len;
		logic             ignore_case;
	} cfg_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
		if (ic && b >= BYTE_LOWER_A && b <= BYTE_LOWER_Z) begin
			return b - CASE_OFFSET;
		end
		return b;
	endfunction

endpackage

FILE: rtl/core/lsm_if.sv
// Stream interfaces for text bytes in and per-byte line results out.
interface lsm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lsm_result_if;
	logic valid;
	logic ready;
	logic line_end;
	logic line_matched;

	modport source (output valid, output line_end, output line_matched, input ready);
	modport sink (input valid, input line_end, input line_matched, output ready);
endinterface

FILE: rtl/core/lsm_cfg.sv
// APB register file holding the keyword, its length and the case mode.
module lsm_cfg
	import lsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY_LOW:     cfg_q.key_low     <= pwdata;
				REG_KEY_HIGH:    cfg_q.key_high    <= pwdata;
				REG_KEY_LEN:     cfg_q.key_len     <= pwdata[LEN_W-1:0];
				REG_IGNORE_CASE: cfg_q.ignore_case <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY_LOW:     prdata = cfg_q.key_low;
			REG_KEY_HIGH:    prdata = cfg_q.key_high;
			REG_KEY_LEN:     prdata = APB_DATA_W'(cfg_q.key_len);
			REG_IGNORE_CASE: prdata = APB_DATA_W'(cfg_q.ignore_case);
		endcase
	end

endmodule

FILE: rtl/core/lsm_cell.sv
// One window cell: compares the byte it receives and holds it for its neighbor.
module lsm_cell
	import lsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic       ignore_case,
	input  logic       care,
	input  logic [7:0] key_byte,
	input  logic [7:0] byte_in,
	input  logic       valid_in,
	output logic [7:0] byte_out,
	output logic       valid_out,
	output logic       ok
);

	logic [7:0] byte_q;
	logic       valid_q;

	// A keyword position outside the length in use always agrees.
	assign ok = !care || (valid_in && key_byte != BYTE_NUL &&
		fold_byte(byte_in, ignore_case) == fold_byte(key_byte, ignore_case));

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= clear ? 1'b0 : valid_in;
		end
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

FILE: rtl/core/line_substring_matcher_core.sv
// Top level: keyword search over a byte stream through a row of window cells.
//
//   port     | dir | kind         | carries
//   ---------+-----+--------------+-------------------------------------------
//   text     | in  | valid/ready  | data_byte, end_of_stream
//   result   | out | valid/ready  | line_end, line_matched
//   apb      | in  | APB, 64 bits | keyword_bytes_low/high, keyword_length,
//            |     |              | ignore_case at byte addresses 0, 8, 16, 24
//
// One byte per cycle unless a full result register is stalled; each request yields its result in the next cycle.
// All cells compare their incoming window byte against the keyword in the
// same cycle, so the cell row and the result register set the rate.
// Reset clears the cell valid bits and line flags; no clearing pass is needed.
// A stalled result holds the input only when the result register is full.
module line_substring_matcher_core
	import lsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	lsm_text_if.sink              text,
	lsm_result_if.source          result
);

	cfg_t cfg;

	logic [7:0]             key_arr [KEY_BYTES];
	logic [7:0]             chain_byte [MAX_KEY_LEN];
	logic                   chain_valid [MAX_KEY_LEN];
	logic [MAX_KEY_LEN-1:0] cell_ok;
	logic [LEN_W-1:0]       len_eff;

	logic accept;
	logic line_end_now;
	logic zero_now;
	logic hit;
	logic match_now;

	logic zero_seen_q;
	logic match_seen_q;
	logic out_valid_q;
	logic line_end_q;
	logic line_matched_q;

	lsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar j = 0; j < KEY_BYTES; j++) begin : g_key
		if (j < 8) begin : g_lo
			assign key_arr[j] = cfg.key_low[8*j +: 8];
		end else begin : g_hi
			assign key_arr[j] = cfg.key_high[8*(j-8) +: 8];
		end
	end

	assign len_eff = (cfg.key_len > LEN_W'(MAX_KEY_LEN)) ? LEN_W'(MAX_KEY_LEN) : cfg.key_len;

	assign accept        = text.valid && text.ready;
	assign text.ready    = !out_valid_q || result.ready;
	assign line_end_now  = (text.data_byte == BYTE_NEWLINE) || text.end_of_stream;
	assign zero_now      = zero_seen_q || (text.data_byte == BYTE_NUL);

	// The incoming byte is window position zero and is always part of the line.
	assign chain_byte[0]  = text.data_byte;
	assign chain_valid[0] = 1'b1;

	for (genvar i = 0; i < MAX_KEY_LEN; i++) begin : g_cell
		logic [LEN_W-1:0]     sel;
		logic [KEY_IDX_W-1:0] idx;
		logic                 care;

		// Window position i lines up with keyword byte len-1-i.
		assign care = LEN_W'(i) < len_eff;
		assign sel  = len_eff - LEN_W'(i) - LEN_W'(1);
		assign idx  = sel[KEY_IDX_W-1:0];

		if (i < MAX_KEY_LEN - 1) begin : g_mid
			lsm_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.shift       (accept),
				.clear       (line_end_now),
				.ignore_case (cfg.ignore_case),
				.care        (care),
				.key_byte    (key_arr[idx]),
				.byte_in     (chain_byte[i]),
				.valid_in    (chain_valid[i]),
				.byte_out    (chain_byte[i+1]),
				.valid_out   (chain_valid[i+1]),
				.ok          (cell_ok[i])
			);
		end else begin : g_last
			lsm_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.shift       (accept),
				.clear       (line_end_now),
				.ignore_case (cfg.ignore_case),
				.care        (care),
				.key_byte    (key_arr[idx]),
				.byte_in     (chain_byte[i]),
				.valid_in    (chain_valid[i]),
				.byte_out    (),
				.valid_out   (),
				.ok          (cell_ok[i])
			);
		end
	end

	assign hit       = (&cell_ok) && (len_eff != '0) && !zero_now;
	assign match_now = match_seen_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seen_q  <= 1'b0;
			match_seen_q <= 1'b0;
		end else if (accept) begin
			zero_seen_q  <= line_end_now ? 1'b0 : zero_now;
			match_seen_q <= line_end_now ? 1'b0 : match_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (text.ready) begin
			out_valid_q <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_end_q     <= line_end_now;
			line_matched_q <= line_end_now && ((len_eff == '0) || match_now);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.line_end     = line_end_q;
	assign result.line_matched = line_matched_q;

	a_line_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end_now |=> !zero_seen_q && !match_seen_q)
		else $error("line flags not cleared after line end");

	a_zero_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !line_end_now && text.data_byte == BYTE_NUL |=> zero_seen_q)
		else $error("zero byte not recorded");

	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end_now |=> !chain_valid[1])
		else $error("window not invalidated at line end");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(line_matched_q))
		else $error("stalled result changed");

endmodule
